/* sv/sorted_score_group_table_unit_macros.svh */
// assertion macros for the sorted score group table
`ifndef SORTED_SCORE_GROUP_TABLE_UNIT_MACROS_SVH
`define SORTED_SCORE_GROUP_TABLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SSTG_ASSERT(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
`define SSTG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SSTG_ASSERT(lbl, clk, rstn, expr)
`define SSTG_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* sv/sstg_pkg.sv */
// shared types and constants of the sorted score group table
`default_nettype none
package sstg_pkg;
    localparam int CAPACITY_DEF  = 64;
    localparam int MAX_GROUP_DEF = 16;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_SORT   = 3'd2,
        OP_GROUP  = 3'd3,
        OP_LIST   = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_NOGROUP  = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_RESP, S_RM_RD, S_RM_CHK, S_SH_RD, S_SH_WR,
        S_SO_KEY_RD, S_SO_KEY, S_SO_CMP_RD, S_SO_CMP, S_SO_PUT,
        S_GR_RD_A, S_GR_RD_B, S_GR_CHK, S_EM_RD, S_EM_OUT
    } state_t;

    typedef struct packed {
        logic [31:0] tstamp;
        logic [15:0] score;
        logic [15:0] id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] id;
        logic [15:0] score;
        logic [31:0] tstamp;
        logic [4:0]  gsz;
        logic [15:0] spread;
    } req_t;

    typedef struct packed {
        status_t    status;
        entry_t     ent;
        logic [6:0] count;
        logic       last;
    } out_item_t;
endpackage
`default_nettype wire

/* sv/sstg_ram.sv */
// generic single-port-write, registered-read ram
`default_nettype none
module sstg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

/* sv/sstg_out.sv */
// output register stage holding one result item
`default_nettype none
module sstg_out (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               ld,
    input  wire sstg_pkg::out_item_t item,
    output logic                    free,
    output logic                    valid,
    input  wire logic               ready,
    output sstg_pkg::out_item_t     item_q
);
    import sstg_pkg::*;

    logic      valid_reg;
    out_item_t item_reg;

    assign free = !valid_reg || ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ld)
        begin
            valid_reg <= 1'b1;
        end
        else if (ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            item_reg <= item;
        end
    end

    assign valid  = valid_reg;
    assign item_q = item_reg;
endmodule
`default_nettype wire

/* sv/sstg_seq.sv */
// sequencer doing read-modify-write passes over the entry memory
`default_nettype none
`include "sorted_score_group_table_unit_macros.svh"
module sstg_seq #(
    parameter int CAPACITY  = sstg_pkg::CAPACITY_DEF,
    parameter int MAX_GROUP = sstg_pkg::MAX_GROUP_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire sstg_pkg::req_t              in_req,
    output logic                             mem_we,
    output logic [$clog2(CAPACITY)-1:0]      mem_waddr,
    output sstg_pkg::entry_t                 mem_wdata,
    output logic                             mem_re,
    output logic [$clog2(CAPACITY)-1:0]      mem_raddr,
    input  wire sstg_pkg::entry_t            mem_rdata,
    output logic                             out_ld,
    output sstg_pkg::out_item_t              out_item,
    input  wire logic                        out_free
);
    import sstg_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] gap_reg, gap_next;
    logic [CW-1:0] n_reg, n_next;
    entry_t        key_reg, key_next;
    logic [15:0]   a_score_reg, a_score_next;
    req_t          req_reg, req_next;
    status_t       status_reg, status_next;

    logic [CW:0]   k_gap_sum;
    logic [CW:0]   grp_end;
    logic [CW:0]   i_k_sum;
    logic [CW:0]   b_addr;
    logic signed [16:0] diff;
    logic          goes_after;
    logic          grp_bad;

    assign k_gap_sum = {1'b0, k_reg} + {1'b0, gap_reg};
    assign grp_end   = {1'b0, i_reg} + {1'b0, gap_reg} + (CW+1)'(1);
    assign i_k_sum   = {1'b0, i_reg} + {1'b0, k_reg};
    assign b_addr    = {1'b0, i_reg} + {1'b0, gap_reg} - (CW+1)'(1);
    assign diff      = $signed({1'b0, mem_rdata.score}) - $signed({1'b0, a_score_reg});
    // strict score order first, timestamp breaks ties, equal keys stay put
    assign goes_after = (mem_rdata.score != key_reg.score) ?
                        (mem_rdata.score > key_reg.score) :
                        (mem_rdata.tstamp > key_reg.tstamp);
    assign grp_bad = (in_req.gsz == 5'd0) || ({3'b0, in_req.gsz} > 8'(MAX_GROUP))
                  || ({3'b0, in_req.gsz} > 8'(count_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        k_reg       <= k_next;
        gap_reg     <= gap_next;
        n_reg       <= n_next;
        key_reg     <= key_next;
        a_score_reg <= a_score_next;
        req_reg     <= req_next;
        status_reg  <= status_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        i_next       = i_reg;
        k_next       = k_reg;
        gap_next     = gap_reg;
        n_next       = n_reg;
        key_next     = key_reg;
        a_score_next = a_score_reg;
        req_next     = req_reg;
        status_next  = status_reg;
        in_ready     = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = k_reg[AW-1:0];
        mem_wdata    = mem_rdata;
        mem_re       = 1'b0;
        mem_raddr    = i_reg[AW-1:0];
        out_ld       = 1'b0;
        out_item.status = status_reg;
        out_item.ent    = '0;
        out_item.count  = '0;
        out_item.last   = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next = in_req;
                    i_next   = '0;
                    k_next   = '0;
                    case (in_req.mode)
                        OP_INSERT:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we           = 1'b1;
                                mem_waddr        = count_reg[AW-1:0];
                                mem_wdata.id     = in_req.id;
                                mem_wdata.score  = in_req.score;
                                mem_wdata.tstamp = in_req.tstamp;
                                count_next       = count_reg + CW'(1);
                                status_next      = ST_OK;
                            end
                            state_next = S_RESP;
                        end
                        OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NOTFOUND;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                state_next = S_RM_RD;
                            end
                        end
                        OP_SORT:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                status_next = ST_OK;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                i_next     = CW'(1);
                                state_next = S_SO_KEY_RD;
                            end
                        end
                        OP_GROUP:
                        begin
                            if (grp_bad)
                            begin
                                status_next = ST_NOGROUP;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                gap_next   = CW'(in_req.gsz);
                                n_next     = CW'(in_req.gsz);
                                state_next = S_GR_RD_A;
                            end
                        end
                        OP_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                n_next     = count_reg;
                                state_next = S_EM_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_ld     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RM_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_RM_CHK;
            end
            S_RM_CHK:
            begin
                if (mem_rdata.id == req_reg.id)
                begin
                    k_next     = i_reg;
                    gap_next   = CW'(1);
                    state_next = S_SH_RD;
                end
                else if (i_reg + CW'(1) == count_reg)
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_RESP;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_RM_RD;
                end
            end
            S_SH_RD:
            begin
                if (k_gap_sum < {1'b0, count_reg})
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = k_gap_sum[AW-1:0];
                    state_next = S_SH_WR;
                end
                else
                begin
                    count_next = count_reg - gap_reg;
                    if (req_reg.mode == OP_REMOVE)
                    begin
                        status_next = ST_OK;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SH_WR:
            begin
                mem_we     = 1'b1;
                k_next     = k_reg + CW'(1);
                state_next = S_SH_RD;
            end
            S_SO_KEY_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_SO_KEY;
            end
            S_SO_KEY:
            begin
                key_next   = mem_rdata;
                k_next     = i_reg;
                state_next = S_SO_CMP_RD;
            end
            S_SO_CMP_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(k_reg - CW'(1));
                state_next = S_SO_CMP;
            end
            S_SO_CMP:
            begin
                if (goes_after)
                begin
                    mem_we     = 1'b1;
                    k_next     = k_reg - CW'(1);
                    state_next = (k_reg == CW'(1)) ? S_SO_PUT : S_SO_CMP_RD;
                end
                else
                begin
                    state_next = S_SO_PUT;
                end
            end
            S_SO_PUT:
            begin
                mem_we    = 1'b1;
                mem_wdata = key_reg;
                if (i_reg + CW'(1) == count_reg)
                begin
                    status_next = ST_OK;
                    state_next  = S_RESP;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_SO_KEY_RD;
                end
            end
            S_GR_RD_A:
            begin
                mem_re     = 1'b1;
                state_next = S_GR_RD_B;
            end
            S_GR_RD_B:
            begin
                a_score_next = mem_rdata.score;
                mem_re       = 1'b1;
                mem_raddr    = b_addr[AW-1:0];
                state_next   = S_GR_CHK;
            end
            S_GR_CHK:
            begin
                if (diff <= $signed({1'b0, req_reg.spread}))
                begin
                    k_next     = '0;
                    state_next = S_EM_RD;
                end
                else if (grp_end > {1'b0, count_reg})
                begin
                    status_next = ST_NOGROUP;
                    state_next  = S_RESP;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_GR_RD_A;
                end
            end
            S_EM_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = i_k_sum[AW-1:0];
                state_next = S_EM_OUT;
            end
            S_EM_OUT:
            begin
                if (out_free)
                begin
                    out_ld          = 1'b1;
                    out_item.status = ST_OK;
                    out_item.ent    = mem_rdata;
                    out_item.count  = 7'(n_reg);
                    out_item.last   = (k_reg + CW'(1) == n_reg);
                    if (k_reg + CW'(1) == n_reg)
                    begin
                        if (req_reg.mode == OP_GROUP)
                        begin
                            k_next     = i_reg;
                            state_next = S_SH_RD;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        k_next     = k_reg + CW'(1);
                        state_next = S_EM_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `SSTG_ASSERT(a_count_bound, clk, rst_n, count_reg <= CW'(CAPACITY))
    `SSTG_ASSERT(a_no_rw_overlap, clk, rst_n, !(mem_we && mem_re))
    `SSTG_ASSERT(a_ld_from_out_state, clk, rst_n,
        !out_ld || state_reg == S_EM_OUT || state_reg == S_RESP)
    `SSTG_ASSERT_NEXT(a_insert_grows, clk, rst_n,
        in_valid && in_ready && in_req.mode == OP_INSERT && count_reg != CW'(CAPACITY),
        count_reg == $past(count_reg) + CW'(1))
endmodule
`default_nettype wire

/* sv/sorted_score_group_table_unit.sv */
// top level of the sorted score group table
// Keeps up to CAPACITY entries (id, score, timestamp) in one registered-read
// ram and runs one operation per input item, selected by s_tuser: insert,
// remove by id, sort, form group, list. One item is worked at a time; s_tready
// is high only while the sequencer is idle. Remove scans for the id and shifts
// the later entries down; sort is an insertion sort; form group tests each
// candidate start, then lists its members and shifts the rest down; list
// reads out every entry. Each step reads one entry or writes one, through the
// single ram port pair.
// Results leave through an output register, so the next item is taken while
// the final result of the previous one still waits on m_tready.
`default_nettype none
module sorted_score_group_table_unit #(
    parameter int CAPACITY  = sstg_pkg::CAPACITY_DEF,
    parameter int MAX_GROUP = sstg_pkg::MAX_GROUP_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // player_id, player_score, player_time, group_size, max_spread, 3 zero bits
    input  wire logic [87:0] s_tdata,
    // mode
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_id, out_score, out_time, out_count, 1 zero bit
    output logic [71:0]      m_tdata,
    // status
    output logic [2:0]       m_tuser,
    output logic             m_tlast
);
    import sstg_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    req_t      req;
    entry_t    wdata, rdata;
    logic      we, re;
    logic [AW-1:0] waddr, raddr;
    logic      ld, free;
    out_item_t item, item_q;
    logic [ENTRY_W-1:0] rdata_raw;

    // unpack request fields from the slave side
    assign req.mode   = s_tuser;
    assign req.id     = s_tdata[15:0];
    assign req.score  = s_tdata[31:16];
    assign req.tstamp = s_tdata[63:32];
    assign req.gsz    = s_tdata[68:64];
    assign req.spread = s_tdata[84:69];

    sstg_seq #(
        .CAPACITY  (CAPACITY),
        .MAX_GROUP (MAX_GROUP)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (req),
        .mem_we    (we),
        .mem_waddr (waddr),
        .mem_wdata (wdata),
        .mem_re    (re),
        .mem_raddr (raddr),
        .mem_rdata (rdata),
        .out_ld    (ld),
        .out_item  (item),
        .out_free  (free)
    );

    // entry store, one ram word per entry
    sstg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    assign rdata = rdata_raw;

    sstg_out u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .ld     (ld),
        .item   (item),
        .free   (free),
        .valid  (m_tvalid),
        .ready  (m_tready),
        .item_q (item_q)
    );

    // pack result fields onto the master side
    assign m_tdata = {1'b0, item_q.count, item_q.ent.tstamp, item_q.ent.score, item_q.ent.id};
    assign m_tuser = item_q.status;
    assign m_tlast = item_q.last;
endmodule
`default_nettype wire

/* sim/tb_sorted_score_group_table_unit.sv */
// testbench for the sorted score group table: predictor, driver, monitor and checks
`timescale 1ns / 1ps
`default_nettype none
module tb_sorted_score_group_table_unit;
    import sstg_pkg::*;

    localparam int CAP  = CAPACITY_DEF;
    localparam int MAXG = MAX_GROUP_DEF;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] id;
        logic [15:0] score;
        logic [31:0] tstamp;
        logic [4:0]  gsz;
        logic [15:0] spread;
    } op_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] id;
        logic [15:0] score;
        logic [31:0] tstamp;
        logic [6:0]  count;
        logic        last;
    } table_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    sorted_score_group_table_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // predictor copy of the table
    logic [15:0] tbl_id [CAP];
    logic [15:0] tbl_score [CAP];
    logic [31:0] tbl_time [CAP];
    int          tbl_n;

    op_item_t      pending_ops[$];
    table_result_t expected_results[$];
    int            mismatch_count;
    bit            long_hold;
    // set at the rising edge that takes the offered item
    bit            in_accepted;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic table_result_t make_result(input logic [2:0] st, input int idx,
                                                  input bit has_entry, input int cnt,
                                                  input bit is_last);
        table_result_t r;
        r.status = st;
        r.id     = has_entry ? tbl_id[idx] : 16'd0;
        r.score  = has_entry ? tbl_score[idx] : 16'd0;
        r.tstamp = has_entry ? tbl_time[idx] : 32'd0;
        r.count  = cnt[6:0];
        r.last   = is_last;
        return r;
    endfunction

    // works out the results of one accepted item and updates the table copy
    task automatic predict_table_op(input op_item_t op);
        int i, j, k, g, diff;
        logic [15:0] hid, hs;
        logic [31:0] ht;
        bit found;
        case (op.mode)
            OP_INSERT:
            begin
                if (tbl_n >= CAP)
                    expected_results.push_back(make_result(ST_FULL, 0, 0, 0, 1));
                else
                begin
                    tbl_id[tbl_n] = op.id;
                    tbl_score[tbl_n] = op.score;
                    tbl_time[tbl_n] = op.tstamp;
                    tbl_n++;
                    expected_results.push_back(make_result(ST_OK, 0, 0, 0, 1));
                end
            end
            OP_REMOVE:
            begin
                found = 0;
                for (i = 0; i < tbl_n && !found; i++)
                    if (tbl_id[i] == op.id)
                    begin
                        found = 1;
                        for (k = i; k + 1 < tbl_n; k++)
                        begin
                            tbl_id[k] = tbl_id[k+1];
                            tbl_score[k] = tbl_score[k+1];
                            tbl_time[k] = tbl_time[k+1];
                        end
                        tbl_n--;
                    end
                expected_results.push_back(make_result(found ? ST_OK : ST_NOTFOUND,
                                                       0, 0, 0, 1));
            end
            OP_SORT:
            begin
                // stable insertion sort on (score, time)
                for (i = 1; i < tbl_n; i++)
                begin
                    hid = tbl_id[i];
                    hs = tbl_score[i];
                    ht = tbl_time[i];
                    j = i;
                    while (j > 0 && (tbl_score[j-1] > hs ||
                                     (tbl_score[j-1] == hs && tbl_time[j-1] > ht)))
                    begin
                        tbl_id[j] = tbl_id[j-1];
                        tbl_score[j] = tbl_score[j-1];
                        tbl_time[j] = tbl_time[j-1];
                        j--;
                    end
                    tbl_id[j] = hid;
                    tbl_score[j] = hs;
                    tbl_time[j] = ht;
                end
                expected_results.push_back(make_result(ST_OK, 0, 0, 0, 1));
            end
            OP_GROUP:
            begin
                g = op.gsz;
                found = 0;
                if (g >= 1 && g <= MAXG && g <= tbl_n)
                    for (i = 0; i + g <= tbl_n && !found; i++)
                    begin
                        // signed spread, negative passes on unsorted tables
                        diff = int'(tbl_score[i+g-1]) - int'(tbl_score[i]);
                        if (diff <= int'(op.spread))
                        begin
                            found = 1;
                            for (k = 0; k < g; k++)
                                expected_results.push_back(make_result(ST_OK, i + k, 1, g,
                                                                       k + 1 == g));
                            for (k = i; k + g < tbl_n; k++)
                            begin
                                tbl_id[k] = tbl_id[k+g];
                                tbl_score[k] = tbl_score[k+g];
                                tbl_time[k] = tbl_time[k+g];
                            end
                            tbl_n -= g;
                        end
                    end
                if (!found)
                    expected_results.push_back(make_result(ST_NOGROUP, 0, 0, 0, 1));
            end
            OP_LIST:
            begin
                if (tbl_n == 0)
                    expected_results.push_back(make_result(ST_EMPTY, 0, 0, 0, 1));
                else
                    for (i = 0; i < tbl_n; i++)
                        expected_results.push_back(make_result(ST_OK, i, 1, tbl_n,
                                                               i + 1 == tbl_n));
            end
            default: ;   // unused modes leave everything unchanged
        endcase
    endtask

    function automatic op_item_t mk_op(input logic [2:0] m, input logic [15:0] id,
                                       input logic [15:0] sc, input logic [31:0] t,
                                       input logic [4:0] g, input logic [15:0] sp);
        op_item_t o;
        o.mode = m; o.id = id; o.score = sc; o.tstamp = t; o.gsz = g; o.spread = sp;
        return o;
    endfunction

    function automatic op_item_t random_op(input int weight_insert);
        int r;
        logic [15:0] sc;
        r = $urandom_range(99);
        // few distinct scores and times so ties and groups are common
        sc = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40));
        if (r < weight_insert)
            return mk_op(OP_INSERT, 16'($urandom_range(15)) | ($urandom_range(5) == 0 ?
                         16'($urandom) : 16'd0), sc,
                         ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(3)),
                         5'($urandom), 16'($urandom));
        else if (r < weight_insert + 12)
            return mk_op(OP_REMOVE, 16'($urandom_range(17)), 16'($urandom), $urandom,
                         5'($urandom), 16'($urandom));
        else if (r < weight_insert + 22)
            return mk_op(OP_SORT, 16'($urandom), 16'($urandom), $urandom,
                         5'($urandom), 16'($urandom));
        else if (r < weight_insert + 40)
            return mk_op(OP_GROUP, 16'($urandom), 16'($urandom), $urandom,
                         ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 5)),
                         ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(10)));
        else if (r < 97)
            return mk_op(OP_LIST, 16'($urandom), 16'($urandom), $urandom,
                         5'($urandom), 16'($urandom));
        else
            return mk_op(3'($urandom_range(5, 7)), 16'($urandom), 16'($urandom), $urandom,
                         5'($urandom), 16'($urandom));
    endfunction

    // sender: bursts of random length with random gaps
    int burst_left;
    int gap_left;
    op_item_t cur_op;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && !in_accepted)
                ;   // hold the offered item
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_ops.size() > 0)
            begin
                cur_op = pending_ops.pop_front();
                s_tdata <= {3'b000, cur_op.spread, cur_op.gsz, cur_op.tstamp,
                            cur_op.score, cur_op.id};
                s_tuser <= cur_op.mode;
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 30);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: own stall pattern, plus a long hold-off on request
    int stall_mode;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(63) == 0)
                stall_mode <= $urandom_range(3);
            case (stall_mode)
                0: m_tready <= !long_hold;
                1: m_tready <= !long_hold && ($urandom_range(1) == 0);
                2: m_tready <= !long_hold && ($urandom_range(7) != 0);
                default: m_tready <= !long_hold && ($urandom_range(5) == 0);
            endcase
        end
    end

    // predictor fed at the input handshake, checker at the output handshake
    always @(posedge clk)
    begin
        in_accepted = rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
            predict_table_op(mk_op(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[63:32],
                                   s_tdata[68:64], s_tdata[84:69]));
        if (rst_n && m_tvalid && m_tready)
        begin
            table_result_t exp_r;
            if (expected_results.size() == 0)
                report_mismatch("result item with no expectation");
            else
            begin
                exp_r = expected_results.pop_front();
                if (m_tuser !== exp_r.status)
                    report_mismatch($sformatf("status %0d exp %0d", m_tuser, exp_r.status));
                if (m_tdata[15:0] !== exp_r.id)
                    report_mismatch($sformatf("id %0h exp %0h", m_tdata[15:0], exp_r.id));
                if (m_tdata[31:16] !== exp_r.score)
                    report_mismatch($sformatf("score %0h exp %0h", m_tdata[31:16],
                                              exp_r.score));
                if (m_tdata[63:32] !== exp_r.tstamp)
                    report_mismatch($sformatf("time %0h exp %0h", m_tdata[63:32],
                                              exp_r.tstamp));
                if (m_tdata[70:64] !== exp_r.count)
                    report_mismatch($sformatf("count %0d exp %0d", m_tdata[70:64],
                                              exp_r.count));
                if (m_tlast !== exp_r.last)
                    report_mismatch($sformatf("last %0b exp %0b", m_tlast, exp_r.last));
            end
        end
    end

    task automatic wait_ops_taken();
        while (pending_ops.size() > 0 || s_tvalid)
            @(posedge clk);
    endtask

    initial
    begin
        int i;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        mismatch_count = 0;
        tbl_n = 0;
        burst_left = 0;
        gap_left = 0;
        stall_mode = 0;
        long_hold = 1'b0;
        in_accepted = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty list, empty group, missing id, extremes, ties, duplicates
        pending_ops.push_back(mk_op(OP_LIST, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(OP_GROUP, 0, 0, 0, 5'd1, 16'hffff));
        pending_ops.push_back(mk_op(OP_REMOVE, 16'hffff, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(OP_INSERT, 16'hffff, 16'hffff, 32'hffffffff, 5'h1f,
                                    16'hffff));
        pending_ops.push_back(mk_op(OP_INSERT, 16'h0000, 16'h0000, 32'h0, 5'h0, 16'h0));
        pending_ops.push_back(mk_op(OP_INSERT, 16'h0007, 16'd5, 32'd9, 0, 0));
        pending_ops.push_back(mk_op(OP_INSERT, 16'h0007, 16'd5, 32'd9, 0, 0));
        pending_ops.push_back(mk_op(OP_INSERT, 16'h0008, 16'd5, 32'd3, 0, 0));
        // negative spread passes before sorting
        pending_ops.push_back(mk_op(OP_GROUP, 0, 0, 0, 5'd2, 16'd0));
        pending_ops.push_back(mk_op(OP_LIST, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(OP_SORT, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(OP_LIST, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(OP_REMOVE, 16'h0007, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(OP_GROUP, 0, 0, 0, 5'd0, 16'hffff));
        pending_ops.push_back(mk_op(OP_GROUP, 0, 0, 0, 5'd17, 16'hffff));
        pending_ops.push_back(mk_op(OP_GROUP, 0, 0, 0, 5'd9, 16'hffff));
        pending_ops.push_back(mk_op(3'd5, 16'h1234, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(3'd7, 16'hffff, 16'hffff, 32'hffffffff, 5'h1f, 16'hffff));
        pending_ops.push_back(mk_op(OP_LIST, 0, 0, 0, 0, 0));
        wait_ops_taken();

        // fill past capacity while the receiver holds off, then a max-size group
        for (i = 0; i < CAP + 2; i++)
            pending_ops.push_back(mk_op(OP_INSERT, 16'(i), 16'($urandom_range(20)),
                                        $urandom, 5'($urandom), 16'($urandom)));
        pending_ops.push_back(mk_op(OP_LIST, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(OP_SORT, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(OP_GROUP, 0, 0, 0, 5'd16, 16'hffff));
        pending_ops.push_back(mk_op(OP_LIST, 0, 0, 0, 0, 0));
        long_hold = 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
        wait_ops_taken();

        // random part: insert-heavy and drain-heavy phases
        for (i = 0; i < 120; i++)
            pending_ops.push_back(random_op(((i / 40) % 2 == 0) ? 55 : 20));
        for (i = 0; i < 20; i++)
            pending_ops.push_back(mk_op(OP_GROUP, 0, 0, 0, 5'd1, 16'hffff));
        wait_ops_taken();
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
